// ----- design/mcgr_pkg.sv -----
// Shared types, constants and helpers for the mesh centroid grasp ranker.
// Used by mcgr_alu and mesh_centroid_grasp_ranker; depends on nothing.

package mcgr_pkg;

  localparam int MAX_FACES  = 1024;
  localparam int MAX_GRASPS = 64;

  localparam int FACE_CW  = $clog2(MAX_FACES + 1);
  localparam int GRASP_CW = $clog2(MAX_GRASPS + 1);
  localparam int GRASP_AW = (MAX_GRASPS > 1) ? $clog2(MAX_GRASPS) : 1;

  localparam int COORD_W  = 16;
  localparam int CFG_W    = 16;
  localparam int Q_W      = 40;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;

  localparam int STEP_CW    = 7;
  localparam int MUL_STEPS  = 64;
  localparam int DIV_STEPS  = 80;
  localparam int SQRT_STEPS = 64;

  localparam logic [CFG_W-1:0] RADIUS_RESET = 16'd256;

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_RADIUS = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_AREA = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_GRASP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd3;

  typedef enum logic [1:0] {
    CMD_FACE   = 2'd0,
    CMD_GRASP  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FACE,
    S_CENT,
    S_QRD,
    S_QUAL,
    S_RRD,
    S_RCMP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] root;
  } alu_rsp_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage

// ----- design/mcgr_alu.sv -----
// Shared iterative arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root over one 68-bit adder. Depends on mcgr_pkg.

module mcgr_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  mcgr_pkg::alu_req_t  req,
  input  logic [63:0]         opa,   // multiplicand or divisor
  input  logic [127:0]        opl,   // multiplier, dividend or radicand
  output mcgr_pkg::alu_rsp_t  rsp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  mcgr_pkg::op_t                   op_r, op_nxt;
  logic [mcgr_pkg::STEP_CW-1:0]    cnt_r, cnt_nxt;
  logic [mcgr_pkg::STEP_CW-1:0]    last_r, last_nxt;
  logic [65:0]                     hi_r, hi_nxt;
  logic [127:0]                    lo_r, lo_nxt;
  logic [63:0]                     root_r, root_nxt;
  logic [63:0]                     a_r, a_nxt;

  logic [67:0] x, y, sum;
  logic        sub, ge;

  always_comb begin
    x   = '0;
    y   = '0;
    sub = 1'b0;
    unique case (op_r)
      mcgr_pkg::OP_MUL: begin
        x = {4'b0, hi_r[63:0]};
        y = {4'b0, (lo_r[0] ? a_r : 64'd0)};
      end
      mcgr_pkg::OP_DIV: begin
        x   = {3'b0, hi_r[63:0], lo_r[127]};
        y   = {4'b0, a_r};
        sub = 1'b1;
      end
      mcgr_pkg::OP_SQRT: begin
        x   = {hi_r, lo_r[127:126]};
        y   = {2'b0, root_r, 2'b01};
        sub = 1'b1;
      end
      default: ;
    endcase
    sum = x + (sub ? ~y : y) + {67'd0, sub};
    ge  = ~sum[67];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    root_nxt = root_r;
    a_nxt    = a_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      hi_nxt   = '0;
      lo_nxt   = opl;
      root_nxt = '0;
      a_nxt    = opa;
      unique case (req.op)
        mcgr_pkg::OP_MUL:  last_nxt = mcgr_pkg::STEP_CW'(mcgr_pkg::MUL_STEPS - 1);
        mcgr_pkg::OP_DIV:  last_nxt = mcgr_pkg::STEP_CW'(mcgr_pkg::DIV_STEPS - 1);
        mcgr_pkg::OP_SQRT: last_nxt = mcgr_pkg::STEP_CW'(mcgr_pkg::SQRT_STEPS - 1);
        default:           last_nxt = '0;
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        mcgr_pkg::OP_MUL: begin
          hi_nxt = {2'b0, sum[64:1]};
          lo_nxt = {lo_r[127:64], sum[0], lo_r[63:1]};
        end
        mcgr_pkg::OP_DIV: begin
          hi_nxt = ge ? {2'b0, sum[63:0]} : {2'b0, x[63:0]};
          lo_nxt = {lo_r[126:0], ge};
        end
        mcgr_pkg::OP_SQRT: begin
          hi_nxt   = ge ? sum[65:0] : x[65:0];
          root_nxt = {root_r[62:0], ge};
          lo_nxt   = {lo_r[125:0], 2'b00};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == last_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= mcgr_pkg::OP_MUL;
      cnt_r  <= '0;
      last_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
    end
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    root_r <= root_nxt;
    a_r    <= a_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.hi   = hi_r[63:0];
  assign rsp.lo   = lo_r[63:0];
  assign rsp.root = root_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("operation started while unit busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r)
    else $error("unit did not begin after start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("done flagged while still busy");

endmodule

// ----- design/mesh_centroid_grasp_ranker.sv -----
// Top level: face accumulation, grasp store, centroid, quality and ranking.
// Depends on mcgr_pkg and mcgr_alu.
//
//  channel | ports                        | contents
//  --------+------------------------------+---------------------------------------
//  in      | in_tvalid/in_tready          | tuser: cmd; tdata: a_x..c_z
//  out     | out_tvalid/out_tready        | tdata: slot, quality, status; tlast
//  cfg     | cfg_we, cfg_addr, cfg_wdata  | 0 gripper_mode, 1 cup_radius
//
// Every product, quotient and root runs on the one mcgr_alu. Finish computes
// the centroid (skipped when the area is zero), then the quality of each
// grasp in standard or suction mode, then emits one ranked beat per grasp.
// in_tready is high only when idle; result beats hold under stall.
// Synchronous reset; no clearing pass.

module mesh_centroid_grasp_ranker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_tuser,   // cmd
  input  logic [143:0]  in_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [47:0]   out_tdata,  // grasp_slot, quality, status
  output logic          out_tlast,  // last_result
  input  logic          cfg_we,
  input  logic          cfg_addr,
  input  logic [15:0]   cfg_wdata
);

  localparam int AW = mcgr_pkg::GRASP_AW;
  localparam int CW = mcgr_pkg::GRASP_CW;
  localparam int FW = mcgr_pkg::FACE_CW;
  localparam int QW = mcgr_pkg::Q_W;

  mcgr_pkg::state_t   state_r, state_nxt;
  logic               mode_r;
  logic [15:0]        radius_r;

  logic [63:0]        wsum_r [3];
  logic [63:0]        wsum_nxt [3];
  logic [47:0]        area_r, area_nxt;
  logic [FW-1:0]      face_cnt_r, face_cnt_nxt;
  logic [CW-1:0]      grasp_cnt_r, grasp_cnt_nxt;
  logic               dropped_r, dropped_nxt;

  logic [15:0]        pa_r [3], pb_r [3], pc_r [3];
  logic [15:0]        pa_nxt [3], pb_nxt [3], pc_nxt [3];
  logic [63:0]        c_r [3], c_nxt [3];
  logic [63:0]        g_r [3], g_nxt [3];
  logic [127:0]       sq_r, sq_nxt;
  logic [35:0]        w_r, w_nxt;
  logic [49:0]        d_r, d_nxt;
  logic [3:0]         step_r, step_nxt;
  logic               issued_r, issued_nxt;
  logic [CW-1:0]      gi_r, gi_nxt;
  logic [CW-1:0]      sc_r, sc_nxt;
  logic [CW-1:0]      oc_r, oc_nxt;
  logic [QW-1:0]      bq_r, bq_nxt, pq_r, pq_nxt;
  logic [AW-1:0]      bi_r, bi_nxt, pi_r, pi_nxt;
  logic               have_r, have_nxt, first_r, first_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [5:0]         oslot_r, oslot_nxt;
  logic [QW-1:0]      oq_r, oq_nxt;
  logic [1:0]         ost_r, ost_nxt;
  logic               olast_r, olast_nxt;

  logic [47:0]        gmem [mcgr_pkg::MAX_GRASPS];
  logic [QW-1:0]      qmem [mcgr_pkg::MAX_GRASPS];
  logic [47:0]        gdata_r;
  logic [QW-1:0]      qdata_r;
  logic               gwe, qwe;
  logic [QW-1:0]      qwd;

  mcgr_pkg::alu_req_t req;
  mcgr_pkg::alu_rsp_t rsp;
  logic [63:0]        opa;
  logic [127:0]       opl;

  mcgr_pkg::cmd_t     cmd;
  logic [16:0]        e1 [3], e2 [3];
  logic [17:0]        vs [3];
  logic [63:0]        dd [3];
  logic [15:0]        rad;
  logic               cand, take;
  logic [QW-1:0]      nb_q;
  logic [AW-1:0]      nb_i;

  mcgr_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .opa   (opa),
    .opl   (opl),
    .rsp   (rsp)
  );

  function automatic logic [63:0] sx17(input logic [16:0] v);
    sx17 = {{47{v[16]}}, v};
  endfunction

  assign cmd = mcgr_pkg::cmd_t'(in_tuser);
  assign rad = (radius_r == '0) ? 16'd1 : radius_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = {pb_r[k][15], pb_r[k]} - {pa_r[k][15], pa_r[k]};
      e2[k] = {pc_r[k][15], pc_r[k]} - {pa_r[k][15], pa_r[k]};
      vs[k] = {{2{pa_r[k][15]}}, pa_r[k]} + {{2{pb_r[k][15]}}, pb_r[k]}
            + {{2{pc_r[k][15]}}, pc_r[k]};
      dd[k] = mcgr_pkg::mag64({{32{gdata_r[16*k+15]}}, gdata_r[16*k +: 16], 16'h0000}
                              - g_r[k]);
    end
  end

  always_comb begin
    cand = first_r || (qdata_r > pq_r)
        || ((qdata_r == pq_r) && (sc_r[AW-1:0] > pi_r));
    take = cand && (!have_r || (qdata_r < bq_r));
    nb_q = take ? qdata_r : bq_r;
    nb_i = take ? sc_r[AW-1:0] : bi_r;
  end

  always_comb begin
    state_nxt     = state_r;
    wsum_nxt      = wsum_r;
    area_nxt      = area_r;
    face_cnt_nxt  = face_cnt_r;
    grasp_cnt_nxt = grasp_cnt_r;
    dropped_nxt   = dropped_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    pc_nxt        = pc_r;
    c_nxt         = c_r;
    g_nxt         = g_r;
    sq_nxt        = sq_r;
    w_nxt         = w_r;
    d_nxt         = d_r;
    step_nxt      = step_r;
    issued_nxt    = issued_r;
    gi_nxt        = gi_r;
    sc_nxt        = sc_r;
    oc_nxt        = oc_r;
    bq_nxt        = bq_r;
    bi_nxt        = bi_r;
    pq_nxt        = pq_r;
    pi_nxt        = pi_r;
    have_nxt      = have_r;
    first_nxt     = first_r;
    st_nxt        = st_r;
    oslot_nxt     = oslot_r;
    oq_nxt        = oq_r;
    ost_nxt       = ost_r;
    olast_nxt     = olast_r;
    req           = '0;
    opa           = '0;
    opl           = '0;
    gwe           = 1'b0;
    qwe           = 1'b0;
    qwd           = rsp.lo[QW-1:0];
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;

    unique case (state_r)
      mcgr_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (cmd)
            mcgr_pkg::CMD_FACE: begin
              if (face_cnt_r < FW'(mcgr_pkg::MAX_FACES)) begin
                for (int k = 0; k < 3; k++) begin
                  pa_nxt[k] = in_tdata[16*k +: 16];
                  pb_nxt[k] = in_tdata[48 + 16*k +: 16];
                  pc_nxt[k] = in_tdata[96 + 16*k +: 16];
                end
                sq_nxt     = '0;
                step_nxt   = '0;
                issued_nxt = 1'b0;
                state_nxt  = mcgr_pkg::S_FACE;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            mcgr_pkg::CMD_GRASP: begin
              if (grasp_cnt_r < CW'(mcgr_pkg::MAX_GRASPS)) begin
                gwe           = 1'b1;
                grasp_cnt_nxt = grasp_cnt_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            mcgr_pkg::CMD_FINISH: begin
              st_nxt     = dropped_r ? mcgr_pkg::ST_DROPPED
                         : ((area_r == '0) ? mcgr_pkg::ST_ZERO_AREA : mcgr_pkg::ST_OK);
              d_nxt      = {1'b0, area_r, 1'b0} + {2'b00, area_r};
              for (int k = 0; k < 3; k++) g_nxt[k] = '0;
              gi_nxt     = '0;
              oc_nxt     = '0;
              sc_nxt     = '0;
              have_nxt   = 1'b0;
              first_nxt  = 1'b1;
              step_nxt   = '0;
              issued_nxt = 1'b0;
              if (grasp_cnt_r == '0) begin
                oslot_nxt = '0;
                oq_nxt    = '0;
                ost_nxt   = mcgr_pkg::ST_NO_GRASP;
                olast_nxt = 1'b1;
                state_nxt = mcgr_pkg::S_EMIT;
              end else if (area_r == '0) begin
                state_nxt = mcgr_pkg::S_QRD;
              end else begin
                state_nxt = mcgr_pkg::S_CENT;
              end
            end
            default: ;
          endcase
        end
      end

      mcgr_pkg::S_FACE: begin
        req.op = mcgr_pkg::OP_MUL;
        case (step_r)
          4'd0: begin opa = sx17(e1[1]); opl = {64'd0, sx17(e2[2])}; end
          4'd1: begin opa = sx17(e1[2]); opl = {64'd0, sx17(e2[1])}; end
          4'd2: begin opa = sx17(e1[2]); opl = {64'd0, sx17(e2[0])}; end
          4'd3: begin opa = sx17(e1[0]); opl = {64'd0, sx17(e2[2])}; end
          4'd4: begin opa = sx17(e1[0]); opl = {64'd0, sx17(e2[1])}; end
          4'd5: begin opa = sx17(e1[1]); opl = {64'd0, sx17(e2[0])}; end
          4'd6: begin
            opa = mcgr_pkg::mag64(c_r[0]);
            opl = {64'd0, mcgr_pkg::mag64(c_r[0])};
          end
          4'd7: begin
            opa = mcgr_pkg::mag64(c_r[1]);
            opl = {64'd0, mcgr_pkg::mag64(c_r[1])};
          end
          4'd8: begin
            opa = mcgr_pkg::mag64(c_r[2]);
            opl = {64'd0, mcgr_pkg::mag64(c_r[2])};
          end
          4'd9: begin
            req.op = mcgr_pkg::OP_SQRT;
            opl    = sq_r;
          end
          4'd10: begin opa = {28'd0, w_r}; opl = {64'd0, {46{vs[0][17]}}, vs[0]}; end
          4'd11: begin opa = {28'd0, w_r}; opl = {64'd0, {46{vs[1][17]}}, vs[1]}; end
          default: begin opa = {28'd0, w_r}; opl = {64'd0, {46{vs[2][17]}}, vs[2]}; end
        endcase
        if (!issued_r) begin
          req.start  = 1'b1;
          issued_nxt = 1'b1;
        end
        if (rsp.done) begin
          issued_nxt = 1'b0;
          step_nxt   = step_r + 1'b1;
          case (step_r)
            4'd0: c_nxt[0] = rsp.lo;
            4'd1: c_nxt[0] = c_r[0] - rsp.lo;
            4'd2: c_nxt[1] = rsp.lo;
            4'd3: c_nxt[1] = c_r[1] - rsp.lo;
            4'd4: c_nxt[2] = rsp.lo;
            4'd5: c_nxt[2] = c_r[2] - rsp.lo;
            4'd6, 4'd7, 4'd8: sq_nxt = sq_r + {rsp.hi, rsp.lo};
            4'd9: begin
              w_nxt    = {rsp.root[34:0], 1'b0};
              area_nxt = area_r + {12'd0, rsp.root[34:0], 1'b0};
            end
            4'd10: wsum_nxt[0] = wsum_r[0] + rsp.lo;
            4'd11: wsum_nxt[1] = wsum_r[1] + rsp.lo;
            default: begin
              wsum_nxt[2]  = wsum_r[2] + rsp.lo;
              face_cnt_nxt = face_cnt_r + 1'b1;
              state_nxt    = mcgr_pkg::S_IDLE;
            end
          endcase
        end
      end

      mcgr_pkg::S_CENT: begin
        req.op = mcgr_pkg::OP_DIV;
        opa    = {14'd0, d_r};
        case (step_r[1:0])
          2'd0:    opl = {mcgr_pkg::mag64(wsum_r[0]), 64'd0};
          2'd1:    opl = {mcgr_pkg::mag64(wsum_r[1]), 64'd0};
          default: opl = {mcgr_pkg::mag64(wsum_r[2]), 64'd0};
        endcase
        if (!issued_r) begin
          req.start  = 1'b1;
          issued_nxt = 1'b1;
        end
        if (rsp.done) begin
          issued_nxt = 1'b0;
          step_nxt   = step_r + 1'b1;
          case (step_r[1:0])
            2'd0: g_nxt[0] = wsum_r[0][63] ? (~rsp.lo + 64'd1) : rsp.lo;
            2'd1: g_nxt[1] = wsum_r[1][63] ? (~rsp.lo + 64'd1) : rsp.lo;
            default: begin
              g_nxt[2]  = wsum_r[2][63] ? (~rsp.lo + 64'd1) : rsp.lo;
              step_nxt  = '0;
              state_nxt = mcgr_pkg::S_QRD;
            end
          endcase
        end
      end

      mcgr_pkg::S_QRD: begin
        sq_nxt     = '0;
        step_nxt   = '0;
        issued_nxt = 1'b0;
        state_nxt  = mcgr_pkg::S_QUAL;
      end

      mcgr_pkg::S_QUAL: begin
        req.op = mcgr_pkg::OP_MUL;
        case (step_r)
          4'd0: begin opa = dd[0]; opl = {64'd0, dd[0]}; end
          4'd1: begin opa = dd[1]; opl = {64'd0, dd[1]}; end
          4'd2: begin opa = dd[2]; opl = {64'd0, dd[2]}; end
          4'd3: begin
            req.op = mcgr_pkg::OP_SQRT;
            opl    = sq_r;
          end
          default: begin
            req.op = mcgr_pkg::OP_DIV;
            opa    = {48'd0, rad};
            opl    = {16'd0, rsp.root, 48'd0};
          end
        endcase
        if (!issued_r) begin
          req.start  = 1'b1;
          issued_nxt = 1'b1;
        end
        if (rsp.done) begin
          issued_nxt = 1'b0;
          case (step_r)
            4'd0, 4'd1, 4'd2: begin
              sq_nxt   = sq_r + {rsp.hi, rsp.lo};
              step_nxt = ((step_r == 4'd1) && !mode_r) ? 4'd3 : (step_r + 1'b1);
            end
            4'd3: begin
              if (mode_r) begin
                qwe = 1'b1;
                qwd = rsp.root[QW-1:0];
              end else begin
                step_nxt = 4'd4;
              end
            end
            default: qwe = 1'b1;
          endcase
          if (qwe) begin
            if (gi_r + 1'b1 == grasp_cnt_r) begin
              sc_nxt    = '0;
              have_nxt  = 1'b0;
              state_nxt = mcgr_pkg::S_RRD;
            end else begin
              gi_nxt    = gi_r + 1'b1;
              state_nxt = mcgr_pkg::S_QRD;
            end
          end
        end
      end

      mcgr_pkg::S_RRD: state_nxt = mcgr_pkg::S_RCMP;

      mcgr_pkg::S_RCMP: begin
        bq_nxt   = nb_q;
        bi_nxt   = nb_i;
        have_nxt = have_r || take;
        if (sc_r + 1'b1 == grasp_cnt_r) begin
          oslot_nxt = 6'(nb_i);
          oq_nxt    = nb_q;
          ost_nxt   = st_r;
          olast_nxt = (oc_r + 1'b1 == grasp_cnt_r);
          pq_nxt    = nb_q;
          pi_nxt    = nb_i;
          first_nxt = 1'b0;
          state_nxt = mcgr_pkg::S_EMIT;
        end else begin
          sc_nxt    = sc_r + 1'b1;
          state_nxt = mcgr_pkg::S_RRD;
        end
      end

      mcgr_pkg::S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (olast_r) begin
            for (int k = 0; k < 3; k++) wsum_nxt[k] = '0;
            area_nxt      = '0;
            face_cnt_nxt  = '0;
            grasp_cnt_nxt = '0;
            dropped_nxt   = 1'b0;
            state_nxt     = mcgr_pkg::S_IDLE;
          end else begin
            oc_nxt    = oc_r + 1'b1;
            sc_nxt    = '0;
            have_nxt  = 1'b0;
            state_nxt = mcgr_pkg::S_RRD;
          end
        end
      end

      default: state_nxt = mcgr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcgr_pkg::S_IDLE;
      wsum_r      <= '{default: '0};
      area_r      <= '0;
      face_cnt_r  <= '0;
      grasp_cnt_r <= '0;
      dropped_r   <= 1'b0;
      issued_r    <= 1'b0;
      step_r      <= '0;
      gi_r        <= '0;
      sc_r        <= '0;
      oc_r        <= '0;
      have_r      <= 1'b0;
      first_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      wsum_r      <= wsum_nxt;
      area_r      <= area_nxt;
      face_cnt_r  <= face_cnt_nxt;
      grasp_cnt_r <= grasp_cnt_nxt;
      dropped_r   <= dropped_nxt;
      issued_r    <= issued_nxt;
      step_r      <= step_nxt;
      gi_r        <= gi_nxt;
      sc_r        <= sc_nxt;
      oc_r        <= oc_nxt;
      have_r      <= have_nxt;
      first_r     <= first_nxt;
    end
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    pc_r    <= pc_nxt;
    c_r     <= c_nxt;
    g_r     <= g_nxt;
    sq_r    <= sq_nxt;
    w_r     <= w_nxt;
    d_r     <= d_nxt;
    bq_r    <= bq_nxt;
    bi_r    <= bi_nxt;
    pq_r    <= pq_nxt;
    pi_r    <= pi_nxt;
    st_r    <= st_nxt;
    oslot_r <= oslot_nxt;
    oq_r    <= oq_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      radius_r <= mcgr_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mcgr_pkg::CFG_MODE:   mode_r   <= cfg_wdata[0];
        mcgr_pkg::CFG_RADIUS: radius_r <= cfg_wdata;
      endcase
    end
  end

  // grasp and quality stores
  always_ff @(posedge clk) begin
    if (gwe) gmem[grasp_cnt_r[AW-1:0]] <= in_tdata[47:0];
    gdata_r <= gmem[gi_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (qwe) qmem[gi_r[AW-1:0]] <= qwd;
    qdata_r <= qmem[sc_r[AW-1:0]];
  end

  assign out_tdata = {ost_r, oq_r, oslot_r};
  assign out_tlast = olast_r;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while a result beat is pending");

  a_grasp_cap: assert property (@(posedge clk) disable iff (!rst_n)
    grasp_cnt_r <= CW'(mcgr_pkg::MAX_GRASPS))
    else $error("grasp count past capacity");

  a_face_cap: assert property (@(posedge clk) disable iff (!rst_n)
    face_cnt_r <= FW'(mcgr_pkg::MAX_FACES))
    else $error("face count past capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (grasp_cnt_r == '0 && area_r == '0))
    else $error("accumulators not cleared after final beat");

  a_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> issued_r)
    else $error("unit result with no operation outstanding");

endmodule
